// ===== sv/mm4_pkg.sv =====
package mm4_pkg;

  // Matrix geometry and number format.
  localparam int unsigned DIM       = 4;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned CELLS     = DIM * DIM;

  // Field widths fixed by the interface.
  localparam int unsigned DataW = 32;
  localparam int unsigned IdxW  = 4;

  // Derived widths.
  localparam int unsigned RowW  = $clog2(DIM);
  localparam int unsigned CellW = $clog2(CELLS);
  localparam int unsigned ProdW = 2 * DataW;
  localparam int unsigned AccW  = ProdW + RowW + 1;

  // Depth of the queue between the loader and the compute engine.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic signed [DataW-1:0] elem_a;
    logic signed [DataW-1:0] elem_b;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] product_value;
    logic [IdxW-1:0]         product_index;
    logic                    last_result;
  } out_item_t;

  // One classified word on its way from the loader to the engine.
  typedef struct packed {
    logic signed [DataW-1:0] elem_a;
    logic signed [DataW-1:0] elem_b;
    logic [CellW-1:0]        pos;
    logic                    last;
  } q_entry_t;

  // Engine status seen by the top level.
  typedef struct packed {
    logic busy;
    logic pop;
    logic pop_last;
  } back_stat_t;

endpackage

// ===== sv/mm4_front.sv =====
module mm4_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mm4_pkg::in_item_t    in_data_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output mm4_pkg::q_entry_t    push_entry_o
);

  logic [mm4_pkg::CellW-1:0] load_cnt_q, load_cnt_d;
  logic                      at_last;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign at_last    = (load_cnt_q == mm4_pkg::CellW'(mm4_pkg::CELLS - 1));

  // Each word is tagged with its position; the final one of a pair is marked.
  always_comb begin
    push_entry_o.elem_a = in_data_i.elem_a;
    push_entry_o.elem_b = in_data_i.elem_b;
    push_entry_o.pos    = load_cnt_q;
    push_entry_o.last   = at_last;
  end

  always_comb begin
    load_cnt_d = load_cnt_q;
    if (push_o) begin
      load_cnt_d = at_last ? '0 : load_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q <= '0;
    end else begin
      load_cnt_q <= load_cnt_d;
    end
  end

endmodule

// ===== sv/mm4_queue.sv =====
module mm4_queue (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  mm4_pkg::q_entry_t              push_entry_i,
  output logic                           full_o,
  input  logic                           pop_i,
  output logic                           valid_o,
  output mm4_pkg::q_entry_t              entry_o,
  output logic [mm4_pkg::QCntW-1:0]      count_o
);

  mm4_pkg::q_entry_t             slots_q [mm4_pkg::QDepth];
  logic [mm4_pkg::QPtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [mm4_pkg::QCntW-1:0]     count_q, count_d;
  logic                          do_push, do_pop;

  assign full_o  = (count_q == mm4_pkg::QCntW'(mm4_pkg::QDepth));
  assign valid_o = (count_q != '0);
  assign entry_o = slots_q[rd_ptr_q];
  assign count_o = count_q;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == mm4_pkg::QPtrW'(mm4_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == mm4_pkg::QPtrW'(mm4_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

endmodule

// ===== sv/mm4_back.sv =====
module mm4_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  mm4_pkg::q_entry_t     q_entry_i,
  output logic                  q_pop_o,
  output mm4_pkg::back_stat_t   stat_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output mm4_pkg::out_item_t    out_data_o
);

  typedef struct packed {
    logic [mm4_pkg::CellW-1:0] elem_idx;
    logic                      first;
    logic                      klast;
  } tag_t;

  // Operand stores, one write port and one registered read port each.
  logic signed [mm4_pkg::DataW-1:0] left_mem  [mm4_pkg::CELLS];
  logic signed [mm4_pkg::DataW-1:0] right_mem [mm4_pkg::CELLS];

  logic                             busy_q, busy_d;
  logic [mm4_pkg::RowW-1:0]         row_q, row_d, col_q, col_d, k_q, k_d;
  logic                             adv, issue, pop;
  logic [mm4_pkg::CellW-1:0]        a_addr, b_addr;
  tag_t                             issue_tag;

  logic                             s1_valid_q, s2_valid_q;
  tag_t                             s1_tag_q, s2_tag_q;
  logic signed [mm4_pkg::DataW-1:0] rd_a_q, rd_b_q;
  logic signed [mm4_pkg::ProdW-1:0] prod_q;
  logic signed [mm4_pkg::AccW-1:0]  acc_q, acc_d, shifted;
  logic signed [mm4_pkg::DataW-1:0] sat_val;
  logic                             res_valid_q, res_valid_d;
  mm4_pkg::out_item_t               res_q;

  localparam int unsigned SatW = mm4_pkg::AccW - mm4_pkg::DataW + 1;

  // The whole compute pipeline moves only when the result register can take a value.
  assign adv     = !res_valid_q || out_ready_i;
  assign issue   = busy_q && adv;
  assign pop     = q_valid_i && !busy_q;
  assign q_pop_o = pop;

  assign stat_o.busy     = busy_q;
  assign stat_o.pop      = pop;
  assign stat_o.pop_last = pop && q_entry_i.last;

  assign a_addr = mm4_pkg::CellW'(row_q * mm4_pkg::DIM + k_q);
  assign b_addr = mm4_pkg::CellW'(k_q * mm4_pkg::DIM + col_q);

  always_comb begin
    issue_tag.elem_idx = mm4_pkg::CellW'(row_q * mm4_pkg::DIM + col_q);
    issue_tag.first    = (k_q == '0);
    issue_tag.klast    = (k_q == mm4_pkg::RowW'(mm4_pkg::DIM - 1));
  end

  // Sequencer: k innermost, then column, then row.
  always_comb begin
    busy_d = busy_q;
    row_d  = row_q;
    col_d  = col_q;
    k_d    = k_q;
    if (pop && q_entry_i.last) begin
      busy_d = 1'b1;
      row_d  = '0;
      col_d  = '0;
      k_d    = '0;
    end else if (issue) begin
      if (k_q != mm4_pkg::RowW'(mm4_pkg::DIM - 1)) begin
        k_d = k_q + 1'b1;
      end else begin
        k_d = '0;
        if (col_q != mm4_pkg::RowW'(mm4_pkg::DIM - 1)) begin
          col_d = col_q + 1'b1;
        end else begin
          col_d = '0;
          if (row_q != mm4_pkg::RowW'(mm4_pkg::DIM - 1)) begin
            row_d = row_q + 1'b1;
          end else begin
            row_d  = '0;
            busy_d = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      left_mem[q_entry_i.pos] <= q_entry_i.elem_a;
    end
    if (issue) begin
      rd_a_q <= left_mem[a_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      right_mem[q_entry_i.pos] <= q_entry_i.elem_b;
    end
    if (issue) begin
      rd_b_q <= right_mem[b_addr];
    end
  end

  // Accumulate and then floor-shift and saturate the finished sum.
  always_comb begin
    acc_d = (s2_tag_q.first ? '0 : acc_q) + mm4_pkg::AccW'(prod_q);
    shifted = acc_d >>> mm4_pkg::FRAC_BITS;
    if (shifted[mm4_pkg::AccW-1:mm4_pkg::DataW-1] == '0 ||
        shifted[mm4_pkg::AccW-1:mm4_pkg::DataW-1] == {SatW{1'b1}}) begin
      sat_val = shifted[mm4_pkg::DataW-1:0];
    end else if (shifted[mm4_pkg::AccW-1]) begin
      sat_val = {1'b1, {(mm4_pkg::DataW-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(mm4_pkg::DataW-1){1'b1}}};
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (adv) begin
      res_valid_d = s2_valid_q && s2_tag_q.klast;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_tag_q <= issue_tag;
      s2_tag_q <= s1_tag_q;
      prod_q   <= rd_a_q * rd_b_q;
      if (s2_valid_q) begin
        acc_q <= acc_d;
      end
      if (s2_valid_q && s2_tag_q.klast) begin
        res_q.product_value <= sat_val;
        res_q.product_index <= mm4_pkg::IdxW'(s2_tag_q.elem_idx);
        res_q.last_result   <= (s2_tag_q.elem_idx == mm4_pkg::CellW'(mm4_pkg::CELLS - 1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      k_q         <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      row_q       <= row_d;
      col_q       <= col_d;
      k_q         <= k_d;
      res_valid_q <= res_valid_d;
      if (adv) begin
        s1_valid_q <= issue;
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

endmodule

// ===== sv/matrix4x4_multiply.sv =====
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_ready_o    in_data_i {elem_a, elem_b}
// out      output     out_valid_o / out_ready_i  out_data_o {product_value, product_index, last_result}
//
// A pair of 4x4 matrices arrives as sixteen words; the sixteenth starts the product.
// The engine then runs 64 multiply-accumulate steps on one shared multiplier, one per
// cycle while the output is not stalled, and takes no new word until all are issued.
// Each step passes the operand read registers and the product register; each finished sum goes to the result register.
// Reset clears the load counter, the queue and the engine, but not the operand stores.
// A stalled output freezes the engine; the loader fills its four-entry queue meanwhile.
module matrix4x4_multiply (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mm4_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mm4_pkg::out_item_t  out_data_o
);

  logic                         push;
  mm4_pkg::q_entry_t            push_entry;
  logic                         q_full;
  logic                         q_pop;
  logic                         q_valid;
  mm4_pkg::q_entry_t            q_entry;
  logic [mm4_pkg::QCntW-1:0]    q_count;
  mm4_pkg::back_stat_t          back_stat;

  // The loader numbers each word and marks the final word of a pair.
  mm4_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  // The queue lets the loader run ahead while the engine is busy or stalled.
  mm4_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .entry_o      (q_entry),
    .count_o      (q_count)
  );

  // The engine stores operands and, on the final word, computes all sixteen results.
  mm4_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .q_pop_o     (q_pop),
    .stat_o      (back_stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef NO_ASSERTIONS
  // The queue never holds more words than it has slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= mm4_pkg::QCntW'(mm4_pkg::QDepth))
    else $error("queue count exceeds depth");

  // Taking the final word of a pair starts the engine on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.pop_last |=> back_stat.busy)
    else $error("engine did not start after final word");

  // The store is never written while the engine is reading it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.busy |-> !back_stat.pop)
    else $error("store written during compute");

  // Only the final product element carries the end mark.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last_result |->
      out_data_o.product_index == mm4_pkg::IdxW'(mm4_pkg::CELLS - 1))
    else $error("end mark on wrong element");
`endif

endmodule

// ===== dv/mm4_check_pkg.sv =====
`timescale 1ns / 1ps

package mm4_check_pkg;
  import mm4_pkg::*;

  // Wide enough for the exact sum of DIM full-precision products.
  typedef logic signed [ProdW+3:0] wide_t;

  class matmul_scoreboard;
    logic signed [DataW-1:0] left_m  [CELLS];
    logic signed [DataW-1:0] right_m [CELLS];
    int unsigned             fill;
    out_item_t               product_q [$];
    int unsigned             failures;
    int unsigned             words_seen;
    int unsigned             products_checked;
    int unsigned             pairs_done;
    int unsigned             saturated;

    function new();
      fill             = 0;
      failures         = 0;
      words_seen       = 0;
      products_checked = 0;
      pairs_done       = 0;
      saturated        = 0;
    endfunction

    // Row r of the left matrix times column c of the right one, scaled back to
    // Q16.16 with a floor shift and clamped to 32 bits.
    function automatic logic signed [DataW-1:0] cell_value(int unsigned r, int unsigned c);
      logic signed [ProdW-1:0] prod;
      wide_t                   acc;
      wide_t                   scaled;
      acc = '0;
      for (int unsigned k = 0; k < DIM; k++) begin
        prod = ProdW'(left_m[r*DIM+k]) * ProdW'(right_m[k*DIM+c]);
        acc += wide_t'(prod);
      end
      scaled = acc >>> FRAC_BITS;
      if (scaled > wide_t'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
      if (scaled < wide_t'(32'sh8000_0000)) return 32'sh8000_0000;
      return scaled[DataW-1:0];
    endfunction

    function void note_word(in_item_t w);
      out_item_t e;
      left_m[fill]  = w.elem_a;
      right_m[fill] = w.elem_b;
      fill++;
      words_seen++;
      if (fill == CELLS) begin
        fill = 0;
        pairs_done++;
        for (int unsigned i = 0; i < CELLS; i++) begin
          e.product_value = cell_value(i / DIM, i % DIM);
          e.product_index = IdxW'(i);
          e.last_result   = (i == CELLS - 1);
          if (e.product_value == 32'sh7FFF_FFFF || e.product_value == 32'sh8000_0000)
            saturated++;
          product_q.push_back(e);
        end
      end
    endfunction

    function void check_product(out_item_t got);
      out_item_t want;
      if (product_q.size() == 0) begin
        $error("unexpected product word: value %0d index %0d last %0b",
               got.product_value, got.product_index, got.last_result);
        failures++;
        return;
      end
      want = product_q.pop_front();
      products_checked++;
      if (got.product_value !== want.product_value) begin
        $error("product_value mismatch: expected %0d, got %0d",
               want.product_value, got.product_value);
        failures++;
      end
      if (got.product_index !== want.product_index) begin
        $error("product_index mismatch: expected %0d, got %0d",
               want.product_index, got.product_index);
        failures++;
      end
      if (got.last_result !== want.last_result) begin
        $error("last_result mismatch: expected %0b, got %0b",
               want.last_result, got.last_result);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return product_q.size();
    endfunction
  endclass

endpackage

// ===== dv/matrix4x4_multiply_tb.sv =====
`timescale 1ns / 1ps

module matrix4x4_multiply_tb;
  import mm4_pkg::*;
  import mm4_check_pkg::*;

  // Random matrix pairs after the directed pair; with it this gives 368 words.
  localparam int unsigned RandomPairs = 22;
  // Cycles without any handshake on either channel before the run is declared hung.
  // Receiver stalls and sender gaps lengthen the legal quiet stretches; the limit is set
  // far beyond the slowest of them.
  localparam int unsigned IdleLimit   = 4000;
  // Settle time after the last expected word, well beyond the engine's latency.
  localparam int unsigned DrainCycles = 40;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;

  matmul_scoreboard sb;
  int unsigned      quiet_cycles;
  int unsigned      burst_left;

  matrix4x4_multiply dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Every handshake is observed at the rising edge, where the block's outputs still
  // hold their pre-edge values and our inputs have been stable since the falling edge.
  // The same process runs the watchdog: it only counts cycles with no word moving.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_word(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_product(out_data_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= IdleLimit) begin
        $display("Timeout: no word moved for %0d cycles", IdleLimit);
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // The receiver stalls on a pattern of its own: it holds each mode for a random stretch,
  // switching between always ready, coin-flip ready, mostly stalled, and a fixed one-in-four
  // rhythm, so that back-pressure lands on every phase of the engine's work.
  initial begin
    int unsigned mode;
    int unsigned len;
    int unsigned phase;
    out_ready_i = 1'b0;
    phase       = 0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(10, 60);
      repeat (len) begin
        @(negedge clk_i);
        phase++;
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= (phase % 4 == 3);
        endcase
      end
    end
  end

  // Offers one input word and returns once it has been accepted. The sender works
  // in bursts: when a burst is used up it drops valid for a random gap, then starts
  // a new burst of random length. A zero gap gives stretches with no idling at all.
  task automatic send_word(input in_item_t w);
    int unsigned gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
  endtask

  // Drops valid and holds off until every expected product word has come back.
  task automatic drain_products();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // A random element. Each pair uses one flavor: small Q16.16 values, values
  // large enough that some sums saturate, or full 32-bit noise. A sprinkling of
  // exact extremes goes into every flavor.
  function automatic logic signed [DataW-1:0] pick_element(int unsigned flavor);
    logic signed [DataW-1:0] v;
    if ($urandom_range(0, 15) == 0) begin
      case ($urandom_range(0, 6))
        0:       v = 32'sh8000_0000;
        1:       v = 32'sh7FFF_FFFF;
        2:       v = 32'sh0000_0000;
        3:       v = 32'shFFFF_FFFF;
        4:       v = 32'sh0001_0000;
        5:       v = 32'shFFFF_0000;
        default: v = 32'sh0000_0001;
      endcase
    end else if (flavor == 0) begin
      v = 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
    end else if (flavor == 1) begin
      v = 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
    end else begin
      v = $urandom();
    end
    return v;
  endfunction

  initial begin
    // The directed pair, row-major. Row 0 of A is all minimum and row 1 all maximum,
    // while column 0 of B is all minimum and column 1 all maximum, so the top-left
    // corner of the product saturates both ways. The remaining rows and columns mix
    // zero, minus one, one, unity and alternating bit patterns, which exercises the
    // floor behavior of the shift on small negative sums.
    logic signed [DataW-1:0] dir_a [CELLS];
    logic signed [DataW-1:0] dir_b [CELLS];
    in_item_t    w;
    int unsigned flavor;

    dir_a = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
              32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
              32'sh0000_0000, 32'shFFFF_FFFF, 32'sh0000_0001, 32'sh0001_0000,
              32'shFFFF_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_8000};
    dir_b = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0001_0000, 32'shFFFF_FFFF,
              32'sh8000_0000, 32'sh7FFF_FFFF, 32'shFFFF_FFFF, 32'sh0000_0001,
              32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000, 32'shAAAA_AAAA,
              32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh5555_5555, 32'sh0000_0000};

    sb           = new();
    quiet_cycles = 0;
    burst_left   = 0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    rst_ni       = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int unsigned i = 0; i < CELLS; i++) begin
      w.elem_a = dir_a[i];
      w.elem_b = dir_b[i];
      send_word(w);
    end
    // Let the whole product come back before random traffic starts.
    drain_products();

    // Random pairs. Fifteen words of a pair only load the stores; the sixteenth
    // starts the product and the next word begins a fresh pair. Now and then the
    // sender waits for the engine to empty completely between pairs.
    for (int unsigned p = 0; p < RandomPairs; p++) begin
      flavor = $urandom_range(0, 2);
      for (int unsigned i = 0; i < CELLS; i++) begin
        w.elem_a = pick_element(flavor);
        w.elem_b = pick_element(flavor);
        send_word(w);
      end
      if ($urandom_range(0, 3) == 0) drain_products();
    end

    drain_products();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Multiplied %0d matrix pairs from %0d words; %0d product words checked.",
             sb.pairs_done, sb.words_seen, sb.products_checked);
    $display("%0d product words sat at a saturation limit; %0d failures.",
             sb.saturated, sb.failures);
    if (sb.failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
